[rtl/siur_pkg.sv]
// ----------------------------------------------------------------------------
// siur_pkg
// Shared types and constants for the serial image upload receiver.
// ----------------------------------------------------------------------------
package siur_pkg;

   localparam int CSR_INDEX_BITS = 4;
   localparam int CSR_DATA_BITS  = 16;

   // configuration register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_LOAD_BASE = 4'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MAX_BYTES = 4'd1;

   localparam logic [14:0] LOAD_BASE_RESET = 15'h4000;
   localparam logic [15:0] MAX_BYTES_RESET = 16'h8000;

   // command bytes
   localparam logic [7:0] CMD_LOAD = 8'h6c;   // 'l'
   localparam logic [7:0] CMD_RUN  = 8'h72;   // 'r'
   localparam logic [7:0] CMD_PING = 8'h70;   // 'p'
   localparam logic [7:0] CHAR_CR  = 8'h0d;
   localparam logic [7:0] CHAR_LF  = 8'h0a;

   typedef enum logic [2:0] {
      STATUS_NONE      = 3'd0,
      STATUS_PONG      = 3'd1,
      STATUS_UNKNOWN   = 3'd2,
      STATUS_SIZE_ERR  = 3'd3,
      STATUS_CKSUM_ERR = 3'd4,
      STATUS_LOADED    = 3'd5,
      STATUS_NO_IMAGE  = 3'd6
   } status_type;

   typedef struct packed {
      logic [14:0] load_base;
      logic [15:0] max_image_bytes;
   } cfg_type;

   typedef struct packed {
      logic        write_enable;
      logic [15:0] write_addr;
      logic [7:0]  write_data;
      status_type  status;
      logic        start_image;
      logic [15:0] loaded_length;
   } result_type;

endpackage

[rtl/siur_frame_engine.sv]
// ----------------------------------------------------------------------------
// siur_frame_engine
// Command decoder and load frame parser; produces one result per byte.
// ----------------------------------------------------------------------------
module siur_frame_engine (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  logic [7:0]           rx_byte,
   input  siur_pkg::cfg_type    cfg,
   output siur_pkg::result_type result
);

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_LEN,
      PH_DATA,
      PH_CKSUM
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [31:0] frame_len_ff, frame_len_in;
   logic [15:0] count_ff, count_in;
   logic [7:0]  xor_ff, xor_in;
   logic        loaded_ff, loaded_in;

   logic [31:0] len_next;
   logic [15:0] count_inc;

   assign len_next  = frame_len_ff | (32'(rx_byte) << {count_ff[1:0], 3'b000});
   assign count_inc = count_ff + 16'd1;

   always_comb begin
      phase_in     = phase_ff;
      frame_len_in = frame_len_ff;
      count_in     = count_ff;
      xor_in       = xor_ff;
      loaded_in    = loaded_ff;
      result       = '0;
      result.status = siur_pkg::STATUS_NONE;
      case (phase_ff)
         PH_IDLE: begin
            if (rx_byte == siur_pkg::CMD_LOAD) begin
               phase_in     = PH_LEN;
               frame_len_in = '0;
               count_in     = '0;
            end else if (rx_byte == siur_pkg::CMD_RUN) begin
               if (loaded_ff) begin
                  result.start_image = 1'b1;
               end else begin
                  result.status = siur_pkg::STATUS_NO_IMAGE;
               end
            end else if (rx_byte == siur_pkg::CMD_PING) begin
               result.status = siur_pkg::STATUS_PONG;
            end else if (!(rx_byte inside {siur_pkg::CHAR_CR, siur_pkg::CHAR_LF})) begin
               result.status = siur_pkg::STATUS_UNKNOWN;
            end
         end
         PH_LEN: begin
            frame_len_in = len_next;
            count_in     = count_inc;
            if (count_ff[1:0] == 2'd3) begin
               count_in = '0;
               xor_in   = '0;
               if (len_next == 32'd0 || len_next > {16'd0, cfg.max_image_bytes}) begin
                  result.status      = siur_pkg::STATUS_SIZE_ERR;
                  result.start_image = loaded_ff;
                  phase_in           = PH_IDLE;
               end else begin
                  phase_in = PH_DATA;
               end
            end
         end
         PH_DATA: begin
            result.write_enable = 1'b1;
            result.write_addr   = {1'b0, cfg.load_base} + count_ff;
            result.write_data   = rx_byte;
            xor_in              = xor_ff ^ rx_byte;
            count_in            = count_inc;
            // length already bounded to 16 bits, so the count never wraps
            if ({16'd0, count_inc} >= frame_len_ff) begin
               phase_in = PH_CKSUM;
            end
         end
         PH_CKSUM: begin
            if (rx_byte == xor_ff) begin
               loaded_in            = 1'b1;
               result.status        = siur_pkg::STATUS_LOADED;
               result.loaded_length = frame_len_ff[15:0];
               result.start_image   = 1'b1;
            end else begin
               result.status      = siur_pkg::STATUS_CKSUM_ERR;
               result.start_image = loaded_ff;
            end
            phase_in = PH_IDLE;
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         frame_len_ff <= '0;
         count_ff     <= '0;
         xor_ff       <= '0;
         loaded_ff    <= 1'b0;
      end else if (accept) begin
         phase_ff     <= phase_in;
         frame_len_ff <= frame_len_in;
         count_ff     <= count_in;
         xor_ff       <= xor_in;
         loaded_ff    <= loaded_in;
      end
   end

endmodule

[rtl/serial_image_upload_receiver.sv]
// ----------------------------------------------------------------------------
// serial_image_upload_receiver
// Serial boot loader front end: command decode, image frame parse, writes.
// ----------------------------------------------------------------------------
// Takes one received byte per transaction and returns exactly one result per
// byte, one byte per clock sustained while rsp_stall is low. Each result is
// computed as its byte is taken and registered in the rsp register or, while
// it is held, in the skid register; the two-entry buffer lets a byte be taken
// while an earlier result waits; req_stall rises only when both are full.
// Configuration writes are taken in any cycle (csr_ready is always high).
module serial_image_upload_receiver (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [7:0]                          req_rx_byte,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_write_enable,
   output logic [15:0]                         rsp_write_addr,
   output logic [7:0]                          rsp_write_data,
   output logic [2:0]                          rsp_status,
   output logic                                rsp_start_image,
   output logic [15:0]                         rsp_loaded_length,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [siur_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [siur_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);

   siur_pkg::cfg_type    cfg_ff;
   siur_pkg::result_type result;
   siur_pkg::result_type out_ff;
   siur_pkg::result_type skid_ff;
   logic                 out_valid_ff;
   logic                 skid_valid_ff;
   logic                 req_accept;
   logic                 out_take;

   assign csr_ready  = 1'b1;
   assign req_stall  = skid_valid_ff;
   assign req_accept = req_valid && !skid_valid_ff;
   assign out_take   = out_valid_ff && !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.load_base       <= siur_pkg::LOAD_BASE_RESET;
         cfg_ff.max_image_bytes <= siur_pkg::MAX_BYTES_RESET;
      end else if (csr_valid && csr_ready) begin
         if (csr_index == siur_pkg::CSR_LOAD_BASE) begin
            cfg_ff.load_base <= csr_wdata[14:0];
         end else if (csr_index == siur_pkg::CSR_MAX_BYTES) begin
            cfg_ff.max_image_bytes <= csr_wdata[15:0];
         end
      end
   end

   siur_frame_engine u_engine (
      .clock   (clock),
      .reset   (reset),
      .accept  (req_accept),
      .rx_byte (req_rx_byte),
      .cfg     (cfg_ff),
      .result  (result)
   );

   // result register with skid behind it
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (out_take) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end
      end else if (req_accept) begin
         if (!out_valid_ff || out_take) begin
            out_valid_ff <= 1'b1;
         end else begin
            skid_valid_ff <= 1'b1;
         end
      end else if (out_take) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (out_take) begin
            out_ff <= skid_ff;
         end
      end else if (req_accept) begin
         if (!out_valid_ff || out_take) begin
            out_ff <= result;
         end else begin
            skid_ff <= result;
         end
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_write_enable  = out_ff.write_enable;
   assign rsp_write_addr    = out_ff.write_addr;
   assign rsp_write_data    = out_ff.write_data;
   assign rsp_status        = out_ff.status;
   assign rsp_start_image   = out_ff.start_image;
   assign rsp_loaded_length = out_ff.loaded_length;

`ifndef NO_ASSERTIONS
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry held without a result in the output register");

   a_write_is_quiet: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_ff.write_enable) |->
         (out_ff.status == siur_pkg::STATUS_NONE && !out_ff.start_image))
      else $error("image byte write carries status or start request");

   a_loaded_starts: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_ff.status == siur_pkg::STATUS_LOADED) |->
         (out_ff.start_image && out_ff.loaded_length != 16'd0))
      else $error("loaded ok without start request or length");

   a_full_stalls: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && skid_valid_ff && rsp_stall) |=> (req_stall && skid_valid_ff))
      else $error("buffer drained while output stalled");
`endif

endmodule
